// ===== rtl/msc_pkg.sv =====
// ----------------------------------------------------------------------------
// MSI snooping cache controller package
// Shared types, codes, default sizes and elaboration helpers.
// ----------------------------------------------------------------------------
package msc_pkg;

  localparam int CACHE_BYTES_DEF = 1024;
  localparam int BLOCK_BYTES_DEF = 16;
  localparam int ADDR_BITS_DEF   = 32;
  localparam int ADDR_W          = 32;

  typedef enum logic [2:0] {
    MODE_READ     = 3'd0,
    MODE_WRITE    = 3'd1,
    MODE_SNP_RD   = 3'd2,
    MODE_SNP_RDX  = 3'd3,
    MODE_FILL_S   = 3'd4,
    MODE_FILL_M   = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_I = 2'd0,
    ST_S = 2'd1,
    ST_M = 2'd2
  } line_state_t;

  typedef enum logic [1:0] {
    REQ_NONE = 2'd0,
    REQ_RD   = 2'd1,
    REQ_RDX  = 2'd2
  } bus_req_t;

  typedef struct packed {
    logic [2:0]        mode;
    logic [ADDR_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic              hit;
    logic [1:0]        bus_request;
    logic [ADDR_W-1:0] request_address;
    logic [1:0]        line_state;
  } out_item_t;

  typedef struct packed {
    logic        hit;
    bus_req_t    bus_request;
    line_state_t line_state;
  } lk_res_t;

  function automatic int floor_log2(input longint v);
    int     n;
    longint t;
    n = 0;
    t = v;
    for (int i = 0; i < 63; i++) begin
      if (t > 1) begin
        t = t >> 1;
        n = n + 1;
      end
    end
    return n;
  endfunction

endpackage

// ===== rtl/msc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module msc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/msc_lookup.sv =====
// ----------------------------------------------------------------------------
// MSI line lookup and update
// Applies one request, snoop or fill to the indexed line and forms the result.
// ----------------------------------------------------------------------------
module msc_lookup #(
  parameter int TAG_W = 22
) (
  input  logic [2:0]           mode,
  input  msc_pkg::line_state_t old_state,
  input  logic [TAG_W-1:0]     old_tag,
  input  logic [TAG_W-1:0]     tag,
  output msc_pkg::line_state_t new_state,
  output logic [TAG_W-1:0]     new_tag,
  output msc_pkg::lk_res_t     res
);

  logic match;

  assign match = (old_state != msc_pkg::ST_I) && (old_tag == tag);

  always_comb begin
    new_state       = old_state;
    new_tag         = old_tag;
    res.hit         = 1'b0;
    res.bus_request = msc_pkg::REQ_NONE;
    unique case (mode) inside
      msc_pkg::MODE_READ: begin
        res.hit = match;
        if (!match) begin
          res.bus_request = msc_pkg::REQ_RD;
        end
      end
      msc_pkg::MODE_WRITE: begin
        res.hit = match;
        if (!match) begin
          res.bus_request = msc_pkg::REQ_RDX;
        end else if (old_state != msc_pkg::ST_M) begin
          new_state       = msc_pkg::ST_M;
          res.bus_request = msc_pkg::REQ_RDX;
        end
      end
      msc_pkg::MODE_SNP_RD: begin
        if (match && old_state == msc_pkg::ST_M) begin
          new_state = msc_pkg::ST_S;
        end
      end
      msc_pkg::MODE_SNP_RDX: begin
        if (match) begin
          new_state = msc_pkg::ST_I;
        end
      end
      msc_pkg::MODE_FILL_S, msc_pkg::MODE_FILL_M: begin
        if (old_state == msc_pkg::ST_I) begin
          new_state = (mode == msc_pkg::MODE_FILL_S) ? msc_pkg::ST_S : msc_pkg::ST_M;
          new_tag   = tag;
        end
      end
      default: begin
      end
    endcase
    res.line_state = new_state;
  end

endmodule

// ===== rtl/msc_pipe.sv =====
// ----------------------------------------------------------------------------
// MSI controller datapath
// Line store, input stage with write forwarding, and result register.
// ----------------------------------------------------------------------------
module msc_pipe #(
  parameter int OB    = 4,
  parameter int IB    = 6,
  parameter int TAG_W = 22,
  parameter logic [31:0] ADDR_MASK = 32'hFFFF_FFFF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  msc_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output msc_pkg::out_item_t out_item,
  output logic               s1_valid
);

  localparam int DEPTH  = 2 ** IB;
  localparam int IDX_W  = (IB > 0) ? IB : 1;
  localparam int LINE_W = TAG_W + 2;
  localparam logic [31:0] IDX_MASK = 32'((64'd1 << IB) - 64'd1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

  logic                 clr_busy_r;
  logic [IDX_W-1:0]     clr_idx_r;
  logic                 v1_r;
  msc_pkg::in_item_t    item_r;
  logic                 fwd_r;
  logic [LINE_W-1:0]    fwd_line_r;
  logic                 out_valid_r;
  msc_pkg::out_item_t   out_item_r;

  logic                 accept;
  logic                 adv;
  logic                 fire;
  logic [31:0]          in_addr_m;
  logic [31:0]          s1_addr_m;
  logic [IDX_W-1:0]     rd_idx;
  logic [IDX_W-1:0]     s1_idx;
  logic [TAG_W-1:0]     s1_tag;
  logic [LINE_W-1:0]    ram_rdata;
  logic [LINE_W-1:0]    cur_line;
  logic [LINE_W-1:0]    upd_line;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [LINE_W-1:0]    ram_wdata;
  msc_pkg::line_state_t new_state;
  logic [TAG_W-1:0]     new_tag;
  msc_pkg::lk_res_t     res;

  assign adv      = !out_valid_r || !out_stall;
  assign fire     = v1_r && adv;
  assign in_stall = clr_busy_r || (v1_r && !adv);
  assign accept   = in_valid && !in_stall;

  assign in_addr_m = in_item.address & ADDR_MASK;
  assign s1_addr_m = item_r.address & ADDR_MASK;
  assign rd_idx    = IDX_W'((in_addr_m >> OB) & IDX_MASK);
  assign s1_idx    = IDX_W'((s1_addr_m >> OB) & IDX_MASK);
  assign s1_tag    = TAG_W'(s1_addr_m >> (OB + IB));

  assign cur_line  = fwd_r ? fwd_line_r : ram_rdata;
  assign upd_line  = {new_state, new_tag};

  assign ram_we    = clr_busy_r || fire;
  assign ram_waddr = clr_busy_r ? clr_idx_r : s1_idx;
  assign ram_wdata = clr_busy_r ? '0 : upd_line;

  msc_ram #(
    .WIDTH (LINE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  msc_lookup #(
    .TAG_W (TAG_W)
  ) u_lookup (
    .mode      (item_r.mode),
    .old_state (msc_pkg::line_state_t'(cur_line[TAG_W +: 2])),
    .old_tag   (cur_line[TAG_W-1:0]),
    .tag       (s1_tag),
    .new_state (new_state),
    .new_tag   (new_tag),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_idx_r   <= '0;
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_idx_r <= clr_idx_r + 1'b1;
        if (clr_idx_r == IDX_LAST) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (accept) begin
        v1_r <= 1'b1;
      end else if (adv) begin
        v1_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r     <= in_item;
      fwd_r      <= fire && (s1_idx == rd_idx);
      fwd_line_r <= upd_line;
    end
    if (fire) begin
      out_item_r.hit             <= res.hit;
      out_item_r.bus_request     <= res.bus_request;
      out_item_r.request_address <= (res.bus_request != msc_pkg::REQ_NONE) ?
                                    item_r.address : '0;
      out_item_r.line_state      <= res.line_state;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign s1_valid  = v1_r;

endmodule

// ===== rtl/msc_pipe_wrap_note.sv =====
// ----------------------------------------------------------------------------
// MSI controller address split
// Derives the offset, index and tag geometry from the cache sizes.
// ----------------------------------------------------------------------------
module msc_geom #(
  parameter int CACHE_BYTES = msc_pkg::CACHE_BYTES_DEF,
  parameter int BLOCK_BYTES = msc_pkg::BLOCK_BYTES_DEF,
  parameter int ADDR_BITS   = msc_pkg::ADDR_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  msc_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output msc_pkg::out_item_t out_item,
  output logic               s1_valid
);

  localparam int OB    = msc_pkg::floor_log2(longint'(BLOCK_BYTES));
  localparam int LINES = CACHE_BYTES / BLOCK_BYTES;
  localparam int IB    = msc_pkg::floor_log2(longint'(LINES));
  localparam int AW    = (ADDR_BITS < 32) ? ADDR_BITS : 32;
  localparam int TAG_W = (AW > OB + IB) ? (AW - OB - IB) : 1;
  localparam logic [31:0] ADDR_MASK =
    (ADDR_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << AW) - 64'd1);

  msc_pipe #(
    .OB        (OB),
    .IB        (IB),
    .TAG_W     (TAG_W),
    .ADDR_MASK (ADDR_MASK)
  ) u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .s1_valid  (s1_valid)
  );

endmodule

// ===== rtl/msi_snooping_cache_controller_core.sv =====
// ----------------------------------------------------------------------------
// MSI snooping cache controller core
// Direct-mapped MSI tag and state controller for reads, writes, snoops, fills.
// ----------------------------------------------------------------------------
// The block takes one item per cycle while in_stall is low: the line store
// is read at acceptance, the item is resolved against the read line in the
// following cycle and the result is registered once the output advances.
// A line updated by the item just ahead is forwarded, so back-to-back items
// to the same line see each other's effects. After reset the line store is
// cleared one line per cycle, all CACHE_BYTES / BLOCK_BYTES lines (rounded down
// to a power of two, at least one), during which in_stall is held high.
module msi_snooping_cache_controller_core #(
  parameter int CACHE_BYTES = msc_pkg::CACHE_BYTES_DEF,
  parameter int BLOCK_BYTES = msc_pkg::BLOCK_BYTES_DEF,
  parameter int ADDR_BITS   = msc_pkg::ADDR_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  msc_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output msc_pkg::out_item_t out_item
);

  logic s1_valid;

  msc_geom #(
    .CACHE_BYTES (CACHE_BYTES),
    .BLOCK_BYTES (BLOCK_BYTES),
    .ADDR_BITS   (ADDR_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .s1_valid  (s1_valid)
  );

`ifndef SYNTHESIS
  a_req_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.bus_request == msc_pkg::REQ_NONE |->
      out_item.request_address == '0)
    else $error("Request address set without a bus request.");

  a_hit_no_busrd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.hit |-> out_item.bus_request != msc_pkg::REQ_RD)
    else $error("BusRd issued on a hit.");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid && !(out_valid && out_stall) |=> out_valid)
    else $error("A resolved item did not reach the result register.");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall && $past(rst_n) && !$past(in_stall) |-> s1_valid && out_valid && out_stall)
    else $error("Input stalled without a blocked item.");
`endif

endmodule
